@@ rtl/core/scc_pkg.sv @@
// shared types, constants and status codes for the stepper command controller
// no dependencies; used by scc_line and stepper_command_controller
`default_nettype none

package scc_pkg;

    localparam int MOTORS   = 3;
    localparam int LINE_MAX = 64;
    localparam int LEN_W    = $clog2(LINE_MAX);
    localparam int STEP_W   = 31;
    localparam int MOTOR_W  = 2;
    localparam int STAT_W   = 4;
    localparam int LVL_W    = 3;

    localparam logic [STEP_W-1:0] STEP_SAT = {STEP_W{1'b1}};

    // result status codes
    localparam logic [STAT_W-1:0] STAT_TICK       = 4'd0;
    localparam logic [STAT_W-1:0] STAT_FORWARD    = 4'd1;
    localparam logic [STAT_W-1:0] STAT_REVERSE    = 4'd2;
    localparam logic [STAT_W-1:0] STAT_STOPPED    = 4'd3;
    localparam logic [STAT_W-1:0] STAT_BAD_PREFIX = 4'd4;
    localparam logic [STAT_W-1:0] STAT_BAD_ID     = 4'd5;
    localparam logic [STAT_W-1:0] STAT_NONNUMERIC = 4'd6;
    localparam logic [STAT_W-1:0] STAT_ZERO_STEPS = 4'd7;
    localparam logic [STAT_W-1:0] STAT_BAD_LETTER = 4'd8;

    // characters
    localparam logic [7:0] CH_M_UP   = 8'h4D;
    localparam logic [7:0] CH_M_LO   = 8'h6D;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_Z_LO   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    // decoded command line, valid for the cycle in which its end byte is taken
    typedef struct packed {
        logic                fire;
        logic [STAT_W-1:0]   status;
        logic [MOTOR_W-1:0]  motor;
        logic [STEP_W-1:0]   steps;
        logic                start;
        logic                stop;
        logic                fwd;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [MOTOR_W-1:0]  motor;
        logic [STEP_W-1:0]   steps;
        logic [LVL_W-1:0]    step_lv;
        logic [LVL_W-1:0]    en_lv;
        logic [LVL_W-1:0]    dir_lv;
        logic [LVL_W-1:0]    done;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/core/scc_line.sv @@
// line assembler and command decoder: collects bytes, decodes a line on cr/lf
// depends on scc_pkg
`default_nettype none

module scc_line (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    output scc_pkg::t_cmd      o_cmd
);

    logic [scc_pkg::LEN_W-1:0]  r_len, n_len;
    logic [7:0]                 r_c1, n_c1;
    logic [7:0]                 r_c2, n_c2;
    logic [7:0]                 r_c3, n_c3;
    logic [scc_pkg::STEP_W-1:0] r_digit, n_digit;
    logic                       r_nondig, n_nondig;

    logic                       w_full;
    logic                       w_eol;
    logic                       w_is_digit;
    logic [scc_pkg::STEP_W+3:0] w_acc;
    logic [7:0]                 w_letter;
    logic                       w_prefix_ok;
    logic                       w_id_ok;

    assign w_full     = (r_len == scc_pkg::LEN_W'(scc_pkg::LINE_MAX - 1));
    assign w_eol      = (i_byte == scc_pkg::CH_CR) || (i_byte == scc_pkg::CH_LF);
    assign w_is_digit = (i_byte inside {[scc_pkg::CH_ZERO:scc_pkg::CH_NINE]});

    // value * 10 + digit, as two shifts and two adds
    assign w_acc = ((scc_pkg::STEP_W+4)'(r_digit) << 3)
                 + ((scc_pkg::STEP_W+4)'(r_digit) << 1)
                 + (scc_pkg::STEP_W+4)'(i_byte - scc_pkg::CH_ZERO);

    always_comb begin
        n_len    = r_len;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_c3     = r_c3;
        n_digit  = r_digit;
        n_nondig = r_nondig;
        if (i_take) begin
            if (w_full || w_eol) begin
                n_len    = '0;
                n_c1     = '0;
                n_c2     = '0;
                n_c3     = '0;
                n_digit  = '0;
                n_nondig = 1'b0;
            end else begin
                n_len = r_len + scc_pkg::LEN_W'(1);
                if (r_len == scc_pkg::LEN_W'(0)) begin
                    n_c1 = i_byte;
                end else if (r_len == scc_pkg::LEN_W'(1)) begin
                    n_c2 = i_byte;
                end else if (r_len == scc_pkg::LEN_W'(2)) begin
                    n_c3 = i_byte;
                end else if (w_is_digit) begin
                    if (w_acc > (scc_pkg::STEP_W+4)'(scc_pkg::STEP_SAT)) begin
                        n_digit = scc_pkg::STEP_SAT;
                    end else begin
                        n_digit = w_acc[scc_pkg::STEP_W-1:0];
                    end
                end else begin
                    n_nondig = 1'b1;
                end
            end
        end
    end

    // decode of the stored line
    always_comb begin
        w_prefix_ok = (r_c1 == scc_pkg::CH_M_UP) || (r_c1 == scc_pkg::CH_M_LO);
        w_id_ok     = (r_len >= scc_pkg::LEN_W'(2))
                   && (r_c2 inside {[scc_pkg::CH_ZERO:scc_pkg::CH_TWO]});
        w_letter    = (r_len < scc_pkg::LEN_W'(3)) ? 8'h00 : r_c3;
        if (w_letter inside {[scc_pkg::CH_A_LO:scc_pkg::CH_Z_LO]}) begin
            w_letter = w_letter - scc_pkg::CASE_DIFF;
        end

        o_cmd       = '0;
        o_cmd.fire  = i_take && !w_full && w_eol && (r_len != '0);
        if (!w_prefix_ok) begin
            o_cmd.status = scc_pkg::STAT_BAD_PREFIX;
        end else if (!w_id_ok) begin
            o_cmd.status = scc_pkg::STAT_BAD_ID;
        end else begin
            o_cmd.motor = scc_pkg::MOTOR_W'(r_c2 - scc_pkg::CH_ZERO);
            case (w_letter)
                scc_pkg::CH_S: begin
                    o_cmd.status = scc_pkg::STAT_STOPPED;
                    o_cmd.stop   = 1'b1;
                end
                scc_pkg::CH_F, scc_pkg::CH_R: begin
                    if (r_nondig) begin
                        o_cmd.status = scc_pkg::STAT_NONNUMERIC;
                    end else if (r_digit == '0) begin
                        o_cmd.status = scc_pkg::STAT_ZERO_STEPS;
                    end else begin
                        o_cmd.fwd    = (w_letter == scc_pkg::CH_F);
                        o_cmd.status = (w_letter == scc_pkg::CH_F) ?
                                       scc_pkg::STAT_FORWARD : scc_pkg::STAT_REVERSE;
                        o_cmd.steps  = r_digit;
                        o_cmd.start  = 1'b1;
                    end
                end
                default: begin
                    o_cmd.status = scc_pkg::STAT_BAD_LETTER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
            r_c3     <= '0;
            r_digit  <= '0;
            r_nondig <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_c1     <= n_c1;
            r_c2     <= n_c2;
            r_c3     <= n_c3;
            r_digit  <= n_digit;
            r_nondig <= n_nondig;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/stepper_command_controller.sv @@
// top level: serial command interpreter driving three step/direction motors
// depends on scc_pkg and scc_line
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | to block  | i_valid / o_stall   | i_command, i_byte_in
//  out     | from block| o_valid / i_stall   | o_status, o_motor_index, o_step_count,
//          |           |                     | o_step_levels, o_enable_levels,
//          |           |                     | o_dir_levels, o_done_mask
//
// one item per cycle while o_stall is low: line state and motor state update at the
// accepting edge, and any result is loaded into the output register at that same
// edge, or into the skid stage behind it while the output is stalled
// a tick always gives a result; a byte only when it ends a nonempty, non-full line
// a one-entry skid stage behind the output register absorbs a result while the
// output is stalled; o_stall rises only when that stage is full
// synchronous active-low reset clears line, motors (direction forward) and valids
`default_nettype none

module stepper_command_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic                          i_command,
    input  wire logic [7:0]                    i_byte_in,
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic [scc_pkg::STAT_W-1:0]    o_status,
    output      logic [scc_pkg::MOTOR_W-1:0]   o_motor_index,
    output      logic [scc_pkg::STEP_W-1:0]    o_step_count,
    output      logic [scc_pkg::LVL_W-1:0]     o_step_levels,
    output      logic [scc_pkg::LVL_W-1:0]     o_enable_levels,
    output      logic [scc_pkg::LVL_W-1:0]     o_dir_levels,
    output      logic [scc_pkg::LVL_W-1:0]     o_done_mask
);

    // item handshake
    logic w_take;
    logic w_tick;
    logic w_byte;

    // per motor state
    logic [scc_pkg::STEP_W-1:0] r_target [scc_pkg::MOTORS];
    logic [scc_pkg::STEP_W-1:0] n_target [scc_pkg::MOTORS];
    logic [scc_pkg::STEP_W-1:0] r_done   [scc_pkg::MOTORS];
    logic [scc_pkg::STEP_W-1:0] n_done   [scc_pkg::MOTORS];
    logic [scc_pkg::MOTORS-1:0] r_moving, n_moving;
    logic [scc_pkg::MOTORS-1:0] r_dir,    n_dir;
    logic [scc_pkg::MOTORS-1:0] r_step,   n_step;
    logic [scc_pkg::MOTORS-1:0] r_en,     n_en;
    logic [scc_pkg::MOTORS-1:0] w_hit;
    logic [scc_pkg::MOTORS-1:0] w_count_ok;

    // result path
    scc_pkg::t_cmd w_cmd;
    scc_pkg::t_res w_res;
    logic          w_res_valid;
    scc_pkg::t_res r_out;
    logic          r_out_valid;
    scc_pkg::t_res r_skid;
    logic          r_skid_valid;
    logic          w_out_free;

    assign o_stall = r_skid_valid;
    assign w_take  = i_valid && !r_skid_valid;
    assign w_tick  = w_take && i_command;
    assign w_byte  = w_take && !i_command;

    scc_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_byte),
        .i_byte  (i_byte_in),
        .o_cmd   (w_cmd)
    );

    // motor bank: tick stepping and command actions, one lane per motor
    always_comb begin
        for (int m = 0; m < scc_pkg::MOTORS; m++) begin
            n_target[m] = r_target[m];
            n_done[m]   = r_done[m];
            n_moving[m] = r_moving[m];
            n_dir[m]    = r_dir[m];
            n_step[m]   = r_step[m];
            n_en[m]     = r_en[m];
            w_hit[m]    = 1'b0;
            // still below target: toggle the step pin and count
            if (w_tick && r_moving[m] && (r_done[m] < r_target[m])) begin
                n_step[m] = !r_step[m];
                n_done[m] = r_done[m] + scc_pkg::STEP_W'(1);
                if (n_done[m] == r_target[m]) begin
                    n_moving[m] = 1'b0;
                    n_en[m]     = 1'b0;
                    w_hit[m]    = 1'b1;
                end
            end
            if (w_cmd.fire && (w_cmd.motor == scc_pkg::MOTOR_W'(m))) begin
                if (w_cmd.stop) begin
                    n_moving[m] = 1'b0;
                    n_target[m] = '0;
                    n_done[m]   = '0;
                    n_en[m]     = 1'b0;
                    n_step[m]   = 1'b0;
                end else if (w_cmd.start) begin
                    n_target[m] = w_cmd.steps;
                    n_done[m]   = '0;
                    n_dir[m]    = w_cmd.fwd;
                    n_moving[m] = 1'b1;
                    n_en[m]     = 1'b1;
                end
            end
            w_count_ok[m] = !r_moving[m] || (r_done[m] < r_target[m]);
        end
    end

    // result built from the levels after the action
    always_comb begin
        w_res_valid   = w_tick || w_cmd.fire;
        w_res         = '0;
        w_res.step_lv = scc_pkg::LVL_W'(n_step);
        w_res.en_lv   = scc_pkg::LVL_W'(n_en);
        w_res.dir_lv  = scc_pkg::LVL_W'(n_dir);
        if (w_tick) begin
            w_res.status = scc_pkg::STAT_TICK;
            w_res.done   = scc_pkg::LVL_W'(w_hit);
        end else begin
            w_res.status = w_cmd.status;
            w_res.motor  = w_cmd.motor;
            w_res.steps  = w_cmd.steps;
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_res_valid;
                end
            end else if (w_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < scc_pkg::MOTORS; m++) begin
                r_target[m] <= '0;
                r_done[m]   <= '0;
            end
            r_moving <= '0;
            r_dir    <= '1;
            r_step   <= '0;
            r_en     <= '0;
        end else begin
            for (int m = 0; m < scc_pkg::MOTORS; m++) begin
                r_target[m] <= n_target[m];
                r_done[m]   <= n_done[m];
            end
            r_moving <= n_moving;
            r_dir    <= n_dir;
            r_step   <= n_step;
            r_en     <= n_en;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_motor_index   = r_out.motor;
    assign o_step_count    = r_out.steps;
    assign o_step_levels   = r_out.step_lv;
    assign o_enable_levels = r_out.en_lv;
    assign o_dir_levels    = r_out.dir_lv;
    assign o_done_mask     = r_out.done;

    // skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    // a driver is enabled exactly while its motor is moving
    a_en_tracks_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en == r_moving)
        else $error("enable and moving disagree");

    // a moving motor is always short of its target
    a_count_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_count_ok)
        else $error("moving motor at or past its target");

    // tick reports carry no motor or step count
    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == scc_pkg::STAT_TICK))
            |-> (r_out.motor == '0) && (r_out.steps == '0))
        else $error("tick report with command fields set");

    // done flags appear only on tick reports
    a_done_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.done != '0)) |-> (r_out.status == scc_pkg::STAT_TICK))
        else $error("done flags on a command result");

endmodule

`default_nettype wire

@@ tb/sv/scc_checker.sv @@
`timescale 1ns / 1ps
// scc_checker: watches both channels of stepper_command_controller, predicts each result
// from the accepted input items and compares it field by field
// depends on scc_pkg
module scc_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic                          i_command,
    input  wire logic [7:0]                    i_byte_in,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [scc_pkg::STAT_W-1:0]    i_status,
    input  wire logic [scc_pkg::MOTOR_W-1:0]   i_motor_index,
    input  wire logic [scc_pkg::STEP_W-1:0]    i_step_count,
    input  wire logic [scc_pkg::LVL_W-1:0]     i_step_levels,
    input  wire logic [scc_pkg::LVL_W-1:0]     i_enable_levels,
    input  wire logic [scc_pkg::LVL_W-1:0]     i_dir_levels,
    input  wire logic [scc_pkg::LVL_W-1:0]     i_done_mask,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import scc_pkg::*;

    // line being assembled
    logic [LEN_W-1:0]  line_len;
    logic [7:0]        ch_prefix;
    logic [7:0]        ch_id;
    logic [7:0]        ch_letter;
    logic [STEP_W-1:0] step_acc;
    logic              bad_digit;

    // motor state
    logic [STEP_W-1:0] tgt [MOTORS];
    logic [STEP_W-1:0] cnt [MOTORS];
    logic [LVL_W-1:0]  running;
    logic [LVL_W-1:0]  fwd_lv;
    logic [LVL_W-1:0]  step_lv;
    logic [LVL_W-1:0]  en_lv;

    t_res expected_q[$];
    int   fails = 0;

    task automatic clear_line();
        line_len  = '0;
        ch_prefix = '0;
        ch_id     = '0;
        ch_letter = '0;
        step_acc  = '0;
        bad_digit = 1'b0;
    endtask

    function automatic t_res report(logic [STAT_W-1:0] st, logic [MOTOR_W-1:0] mi,
                                    logic [STEP_W-1:0] sc, logic [LVL_W-1:0] dm);
        t_res r;
        r.status  = st;
        r.motor   = mi;
        r.steps   = sc;
        r.step_lv = step_lv;
        r.en_lv   = en_lv;
        r.dir_lv  = fwd_lv;
        r.done    = dm;
        return r;
    endfunction

    task automatic predict_item(input logic cmd, input logic [7:0] c,
                                output logic has, output t_res r);
        logic [LVL_W-1:0]   done;
        logic [MOTOR_W-1:0] id;
        logic [7:0]         letter;
        logic [STEP_W-1:0]  d;
        int                 m;
        has  = 1'b0;
        r    = '0;
        done = '0;
        if (cmd) begin
            for (m = 0; m < MOTORS; m++) begin
                if (running[m] && cnt[m] < tgt[m]) begin
                    step_lv[m] = ~step_lv[m];
                    cnt[m]     = cnt[m] + 1'b1;
                    if (cnt[m] >= tgt[m]) begin
                        running[m] = 1'b0;
                        en_lv[m]   = 1'b0;
                        done[m]    = 1'b1;
                    end
                end
            end
            has = 1'b1;
            r   = report(STAT_TICK, '0, '0, done);
        end else if (line_len >= LINE_MAX - 1) begin
            // full line: any byte throws it away
            clear_line();
        end else if (c == CH_CR || c == CH_LF) begin
            if (line_len != 0) begin
                has = 1'b1;
                if (ch_prefix != CH_M_UP && ch_prefix != CH_M_LO) begin
                    r = report(STAT_BAD_PREFIX, '0, '0, '0);
                end else if (line_len < 2 || ch_id < CH_ZERO || ch_id > CH_TWO) begin
                    r = report(STAT_BAD_ID, '0, '0, '0);
                end else begin
                    id     = MOTOR_W'(ch_id - CH_ZERO);
                    letter = (line_len < 3) ? 8'h00 : ch_letter;
                    if (letter >= CH_A_LO && letter <= CH_Z_LO)
                        letter = letter - CASE_DIFF;
                    if (letter == CH_S) begin
                        running[id] = 1'b0;
                        tgt[id]     = '0;
                        cnt[id]     = '0;
                        en_lv[id]   = 1'b0;
                        step_lv[id] = 1'b0;
                        r = report(STAT_STOPPED, id, '0, '0);
                    end else if (letter == CH_F || letter == CH_R) begin
                        if (bad_digit) begin
                            r = report(STAT_NONNUMERIC, id, '0, '0);
                        end else if (step_acc == 0) begin
                            r = report(STAT_ZERO_STEPS, id, '0, '0);
                        end else begin
                            tgt[id]     = step_acc;
                            cnt[id]     = '0;
                            fwd_lv[id]  = (letter == CH_F);
                            running[id] = 1'b1;
                            en_lv[id]   = 1'b1;
                            r = report((letter == CH_F) ? STAT_FORWARD : STAT_REVERSE,
                                       id, step_acc, '0);
                        end
                    end else begin
                        r = report(STAT_BAD_LETTER, id, '0, '0);
                    end
                end
                clear_line();
            end
        end else begin
            case (line_len)
                0: ch_prefix = c;
                1: ch_id     = c;
                2: ch_letter = c;
                default: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        d = STEP_W'(c - CH_ZERO);
                        if (step_acc > (STEP_SAT - d) / 10)
                            step_acc = STEP_SAT;
                        else
                            step_acc = step_acc * 10 + d;
                    end else begin
                        bad_digit = 1'b1;
                    end
                end
            endcase
            line_len = line_len + 1'b1;
        end
    endtask

    task automatic check_field(string fname, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res want;
        t_res next_res;
        logic has_res;
        int   m;
        if (!i_rst_n) begin
            clear_line();
            for (m = 0; m < MOTORS; m++) begin
                tgt[m] = '0;
                cnt[m] = '0;
            end
            running = '0;
            fwd_lv  = '1;
            step_lv = '0;
            en_lv   = '0;
            expected_q.delete();
        end else begin
            // results leave only after their item is registered, so compare first
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: status %0d motor %0d steps %0d",
                             $time, i_status, i_motor_index, i_step_count);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("motor_index", want.motor, i_motor_index);
                    check_field("step_count", want.steps, i_step_count);
                    check_field("step_levels", want.step_lv, i_step_levels);
                    check_field("enable_levels", want.en_lv, i_enable_levels);
                    check_field("dir_levels", want.dir_lv, i_dir_levels);
                    check_field("done_mask", want.done, i_done_mask);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_item(i_command, i_byte_in, has_res, next_res);
                if (has_res)
                    expected_q.push_back(next_res);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: stimulus and verdict for stepper_command_controller
// depends on scc_pkg, scc_checker and the block itself
module tb;
    import scc_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int IDLE_PCT       = 26;
    localparam int ITEM_TARGET    = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic                i_command = 1'b0;
    logic [7:0]          i_byte_in = 8'h00;
    logic                i_stall   = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [MOTOR_W-1:0]  o_motor_index;
    logic [STEP_W-1:0]   o_step_count;
    logic [LVL_W-1:0]    o_step_levels;
    logic [LVL_W-1:0]    o_enable_levels;
    logic [LVL_W-1:0]    o_dir_levels;
    logic [LVL_W-1:0]    o_done_mask;

    int         fail_count;
    int         pending;
    int         items_sent   = 0;
    int         quiet_cycles = 0;
    bit         calm         = 1'b0;   // no idling on either side while set
    logic [7:0] line_buf[$];           // bytes of the next line to send

    always #(HALF_PERIOD) i_clk = ~i_clk;

    stepper_command_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_byte_in       (i_byte_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_motor_index   (o_motor_index),
        .o_step_count    (o_step_count),
        .o_step_levels   (o_step_levels),
        .o_enable_levels (o_enable_levels),
        .o_dir_levels    (o_dir_levels),
        .o_done_mask     (o_done_mask)
    );

    scc_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_command       (i_command),
        .i_byte_in       (i_byte_in),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_status        (o_status),
        .i_motor_index   (o_motor_index),
        .i_step_count    (o_step_count),
        .i_step_levels   (o_step_levels),
        .i_enable_levels (o_enable_levels),
        .i_dir_levels    (o_dir_levels),
        .i_done_mask     (o_done_mask),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // receiver back-pressure, off during reset and in the calm stretch
    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // watchdog: too long without any handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one item: random idle cycles first, then hold until accepted
    task automatic send_item(logic cmd, logic [7:0] b);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid   <= 1'b0;
            i_byte_in <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_byte_in <= b;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endtask

    task automatic flush_line();
        foreach (line_buf[k])
            send_item(1'b0, line_buf[k]);
        line_buf.delete();
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(1'b1, 8'($urandom));
    endtask

    function automatic logic [7:0] any_case(logic [7:0] c);
        return $urandom_range(0, 1) ? (c | CASE_DIFF) : c;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CH_CR : CH_LF;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // a motor command; when broken, one part of it is spoiled
    task automatic queue_command(bit broken);
        int spoil;
        int sel;
        spoil = broken ? $urandom_range(1, 7) : 0;
        line_buf.push_back(spoil == 1 ? 8'($urandom) : any_case(CH_M_UP));
        if (spoil == 2) begin
            // prefix alone, or a random id byte
            if ($urandom_range(0, 1))
                line_buf.push_back(8'($urandom));
            line_buf.push_back(line_end());
            return;
        end
        line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 2)));
        if (spoil == 3) begin
            // missing or random letter
            if ($urandom_range(0, 1))
                line_buf.push_back(8'($urandom));
            line_buf.push_back(line_end());
            return;
        end
        sel = $urandom_range(0, 9);
        line_buf.push_back(any_case(sel < 3 ? CH_S : (sel < 7 ? CH_F : CH_R)));
        case (spoil)
            4: ;  // empty step field
            5: repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
            6: repeat ($urandom_range(10, 15)) line_buf.push_back(rand_digit());
            default: begin
                if ($urandom_range(0, 9) == 0)
                    push_text($sformatf("%0d", $urandom_range(13, 200)));
                else
                    push_text($sformatf("%0d", $urandom_range(1, 12)));
            end
        endcase
        if (spoil == 7) begin
            // stray character among the digits
            line_buf.push_back(8'($urandom));
            if ($urandom_range(0, 1))
                line_buf.push_back(rand_digit());
        end
        line_buf.push_back(line_end());
    endtask

    // a line right around the length limit; a short one saturates the count
    task automatic queue_long_line();
        int n;
        n = $urandom_range(LINE_MAX - 3, LINE_MAX + 2);
        line_buf.push_back(any_case(CH_M_UP));
        line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 2)));
        line_buf.push_back(any_case($urandom_range(0, 1) ? CH_F : CH_R));
        repeat (n - 3) line_buf.push_back(rand_digit());
        line_buf.push_back(line_end());
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 8))
            line_buf.push_back($urandom_range(0, 4) == 0 ? 8'h00 : 8'($urandom));
        line_buf.push_back(line_end());
    endtask

    initial begin : stimulus
        int pick;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a full move and its done tick, empty step field, stop,
        // empty line, zero byte, prefix alone, line without a letter
        push_text("M0F3");
        line_buf.push_back(CH_CR);
        flush_line();
        send_ticks(3);
        push_text("m1r");
        line_buf.push_back(CH_LF);
        flush_line();
        push_text("M2s");
        line_buf.push_back(CH_CR);
        flush_line();
        line_buf.push_back(CH_CR);
        flush_line();
        line_buf.push_back(8'h00);
        line_buf.push_back(CH_CR);
        flush_line();
        push_text("m");
        line_buf.push_back(CH_LF);
        flush_line();
        push_text("M0");
        line_buf.push_back(CH_CR);
        flush_line();

        // random: mostly well-formed commands and ticks, mixed with broken lines, noise and long lines
        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 800 && items_sent < 1100);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_ticks($urandom_range(1, 6));
            else if (pick < 75)
                queue_command(1'b0);
            else if (pick < 90)
                queue_command(1'b1);
            else if (pick < 96)
                queue_noise();
            else
                queue_long_line();
            flush_line();
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
